FILE: rtl/tpi_pkg.sv
`timescale 1ns / 1ps
package tpi_pkg;

    localparam int NORMAL_FRAC_BITS = 30;
    localparam int IN_W      = 32;
    localparam int NUM_IN    = 12;
    localparam int NUM_DET   = 4;
    localparam int NUM_TERMS = 6;
    localparam int PROD_W    = 2 * IN_W;
    localparam int TERM_W    = 3 * IN_W;
    localparam int DET_W     = TERM_W + 2;
    localparam int REM_W     = DET_W - 1 + NORMAL_FRAC_BITS + 1;
    localparam int BIG_W     = REM_W + 2;
    localparam int Q_W       = 32;
    localparam int THR_SHIFT = 2 * NORMAL_FRAC_BITS;
    localparam int DET_MIN_W = 31;

    localparam logic [DET_MIN_W-1:0] DET_MIN_RESET =
        DET_MIN_W'(((64'd1 << NORMAL_FRAC_BITS) + 64'd5000) / 64'd10000);

    localparam logic [Q_W-1:0] Q_POS_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] Q_NEG_MAX = {1'b1, {(Q_W-1){1'b0}}};

    // Column picked in each row for the six terms of a 3x3 determinant.
    // The last three terms are subtracted.
    localparam logic [1:0] PERM [NUM_TERMS][3] = '{
        '{2'd0, 2'd1, 2'd2},
        '{2'd1, 2'd2, 2'd0},
        '{2'd2, 2'd0, 2'd1},
        '{2'd2, 2'd1, 2'd0},
        '{2'd1, 2'd0, 2'd2},
        '{2'd0, 2'd2, 2'd1}
    };

    typedef logic [REM_W-1:0] rem_t;

    typedef struct packed {
        logic       singular;
        logic [2:0] neg;
        logic [2:0] big;
    } cell_ctl_t;

    typedef struct packed {
        cell_ctl_t               ctl;
        rem_t                    ds;
        rem_t [2:0]              rem;
        logic [2:0][Q_W-1:0]     q;
    } cell_t;

endpackage

FILE: rtl/tpi_if.sv
`timescale 1ns / 1ps
interface tpi_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] plane1_nx;
    logic signed [31:0] plane1_ny;
    logic signed [31:0] plane1_nz;
    logic signed [31:0] plane1_off;
    logic signed [31:0] plane2_nx;
    logic signed [31:0] plane2_ny;
    logic signed [31:0] plane2_nz;
    logic signed [31:0] plane2_off;
    logic signed [31:0] plane3_nx;
    logic signed [31:0] plane3_ny;
    logic signed [31:0] plane3_nz;
    logic signed [31:0] plane3_off;

    modport source (output valid, plane1_nx, plane1_ny, plane1_nz, plane1_off,
                    plane2_nx, plane2_ny, plane2_nz, plane2_off,
                    plane3_nx, plane3_ny, plane3_nz, plane3_off, input ready);
    modport sink (input valid, plane1_nx, plane1_ny, plane1_nz, plane1_off,
                  plane2_nx, plane2_ny, plane2_nz, plane2_off,
                  plane3_nx, plane3_ny, plane3_nz, plane3_off, output ready);
endinterface

interface tpi_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               singular;
    logic               saturated;

    modport source (output valid, point_x, point_y, point_z, singular, saturated,
                    input ready);
    modport sink (input valid, point_x, point_y, point_z, singular, saturated,
                  output ready);
endinterface

interface tpi_cfg_if;
    logic        valid;
    logic        ready;
    logic [30:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

FILE: rtl/tpi_front.sv
`timescale 1ns / 1ps
module tpi_front (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           en,
    input  logic                                           in_valid,
    input  logic signed [tpi_pkg::NUM_IN-1:0][tpi_pkg::IN_W-1:0] v,
    input  logic [tpi_pkg::DET_MIN_W-1:0]                  det_min,
    output logic                                           out_valid,
    output tpi_pkg::cell_t                                 out_data
);
    import tpi_pkg::*;

    logic signed [PROD_W-1:0]   ab_reg   [NUM_DET][NUM_TERMS];
    logic signed [IN_W-1:0]     c_reg    [NUM_DET][NUM_TERMS];
    logic signed [PROD_W-1:0]   phi_reg  [NUM_DET][NUM_TERMS];
    logic signed [PROD_W:0]     plo_reg  [NUM_DET][NUM_TERMS];
    logic signed [TERM_W-1:0]   term_reg [NUM_DET][NUM_TERMS];
    logic signed [DET_W-1:0]    sum_reg  [NUM_DET];
    logic signed [DET_W-1:0]    sum_next [NUM_DET];
    logic [3:0]                 vld_reg;
    cell_t                      data_next;
    logic [DET_W-1:0]           adet;
    logic [DET_W-1:0]           anum     [3];
    rem_t                       nshift   [3];

    // Element of matrix m: the normals, with one column swapped for offsets
    // in the three numerator determinants.
    function automatic logic signed [IN_W-1:0] elem(
        input logic signed [NUM_IN-1:0][IN_W-1:0] vv, input int m, input int row,
        input logic [1:0] col);
        logic signed [IN_W-1:0] r;
        if (m != 0 && int'(col) == m - 1)
            r = vv[4 * row + 3];
        else
            r = vv[4 * row + int'(col)];
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int m = 0; m < NUM_DET; m++)
            begin
                for (int t = 0; t < NUM_TERMS; t++)
                begin
                    ab_reg[m][t] <= PROD_W'(elem(v, m, 0, PERM[t][0]))
                                  * PROD_W'(elem(v, m, 1, PERM[t][1]));
                    c_reg[m][t]  <= elem(v, m, 2, PERM[t][2]);
                    phi_reg[m][t] <= PROD_W'($signed(ab_reg[m][t][PROD_W-1:IN_W]))
                                   * PROD_W'(c_reg[m][t]);
                    plo_reg[m][t] <= (PROD_W+1)'($signed({1'b0, ab_reg[m][t][IN_W-1:0]}))
                                   * (PROD_W+1)'(c_reg[m][t]);
                    term_reg[m][t] <= $signed({phi_reg[m][t], {IN_W{1'b0}}})
                                    + TERM_W'(plo_reg[m][t]);
                end
                sum_reg[m] <= sum_next[m];
            end
        end
    end

    always_comb
    begin
        for (int m = 0; m < NUM_DET; m++)
        begin
            sum_next[m] = '0;
            for (int t = 0; t < NUM_TERMS; t++)
            begin
                if (t < 3)
                    sum_next[m] = sum_next[m] + DET_W'(term_reg[m][t]);
                else
                    sum_next[m] = sum_next[m] - DET_W'(term_reg[m][t]);
            end
        end
    end

    always_comb
    begin
        adet = sum_reg[0][DET_W-1] ? DET_W'(-sum_reg[0]) : DET_W'(sum_reg[0]);
        data_next.ctl.singular = (adet == '0)
            || (REM_W'(adet) < (REM_W'(det_min) << THR_SHIFT));
        data_next.ds = REM_W'(adet) << (Q_W - 1);
        for (int k = 0; k < 3; k++)
        begin
            anum[k] = sum_reg[k+1][DET_W-1] ? DET_W'(-sum_reg[k+1])
                                            : DET_W'(sum_reg[k+1]);
            nshift[k] = REM_W'(anum[k]) << NORMAL_FRAC_BITS;
            data_next.ctl.neg[k] = sum_reg[k+1][DET_W-1] ^ sum_reg[0][DET_W-1];
            data_next.ctl.big[k] = BIG_W'(nshift[k]) >= (BIG_W'(adet) << Q_W);
            data_next.rem[k] = nshift[k];
            data_next.q[k] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (en)
            out_valid <= vld_reg[3];
    end
endmodule

FILE: rtl/tpi_cell.sv
`timescale 1ns / 1ps
module tpi_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  tpi_pkg::cell_t in_data,
    output logic           out_valid,
    output tpi_pkg::cell_t out_data
);
    import tpi_pkg::*;

    cell_t      data_next;
    logic [2:0] ge;

    // One quotient bit per lane: the divisor arrives pre-shifted for this bit.
    always_comb
    begin
        data_next = in_data;
        data_next.ds = in_data.ds >> 1;
        for (int k = 0; k < 3; k++)
        begin
            ge[k] = in_data.rem[k] >= in_data.ds;
            data_next.rem[k] = ge[k] ? in_data.rem[k] - in_data.ds : in_data.rem[k];
            data_next.q[k] = {in_data.q[k][Q_W-2:0], ge[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (en)
            out_valid <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data <= data_next;
    end
endmodule

FILE: rtl/three_plane_intersection.sv
`timescale 1ns / 1ps
// Throughput: one query per cycle; five product/sum stages, then a chain of 32
// division cells that each settle one quotient bit for all three coordinates.
// The whole pipeline stalls only while the output register holds an untaken result.
// Reset clears all valid bits and loads det_min with its default of 1e-4.
module three_plane_intersection (
    input  logic       clk,
    input  logic       rst_n,
    tpi_in_if.sink     query,
    tpi_out_if.source  res,
    tpi_cfg_if.sink    cfg
);
    import tpi_pkg::*;

    logic                              en;
    logic signed [NUM_IN-1:0][IN_W-1:0] v;
    logic [DET_MIN_W-1:0]              det_min_reg;
    logic                              vld    [Q_W+1];
    cell_t                             stage  [Q_W+1];
    logic                              out_valid_reg;
    logic signed [IN_W-1:0]            point_reg [3];
    logic signed [IN_W-1:0]            point_next [3];
    logic                              singular_reg;
    logic                              saturated_reg;
    logic                              saturated_next;
    logic [Q_W-1:0]                    qv;
    cell_t                             last;

    assign en = !out_valid_reg || res.ready;
    assign query.ready = en;
    assign cfg.ready = 1'b1;

    assign v[0]  = query.plane1_nx;
    assign v[1]  = query.plane1_ny;
    assign v[2]  = query.plane1_nz;
    assign v[3]  = query.plane1_off;
    assign v[4]  = query.plane2_nx;
    assign v[5]  = query.plane2_ny;
    assign v[6]  = query.plane2_nz;
    assign v[7]  = query.plane2_off;
    assign v[8]  = query.plane3_nx;
    assign v[9]  = query.plane3_ny;
    assign v[10] = query.plane3_nz;
    assign v[11] = query.plane3_off;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            det_min_reg <= DET_MIN_RESET;
        else if (cfg.valid)
            det_min_reg <= cfg.data;
    end

    tpi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (query.valid),
        .v         (v),
        .det_min   (det_min_reg),
        .out_valid (vld[0]),
        .out_data  (stage[0])
    );

    for (genvar i = 0; i < Q_W; i++)
    begin : g_cell
        tpi_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (vld[i]),
            .in_data   (stage[i]),
            .out_valid (vld[i+1]),
            .out_data  (stage[i+1])
        );
    end

    assign last = stage[Q_W];

    always_comb
    begin
        saturated_next = 1'b0;
        qv = '0;
        for (int k = 0; k < 3; k++)
        begin
            qv = last.q[k];
            if (last.ctl.neg[k])
            begin
                if (last.ctl.big[k] || qv > Q_NEG_MAX)
                begin
                    point_next[k] = $signed(Q_NEG_MAX);
                    saturated_next = 1'b1;
                end
                else
                    point_next[k] = $signed(-qv);
            end
            else
            begin
                if (last.ctl.big[k] || qv[Q_W-1])
                begin
                    point_next[k] = $signed(Q_POS_MAX);
                    saturated_next = 1'b1;
                end
                else
                    point_next[k] = $signed(qv);
            end
            if (last.ctl.singular)
                point_next[k] = '0;
        end
        if (last.ctl.singular)
            saturated_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= vld[Q_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
                point_reg[k] <= point_next[k];
            singular_reg  <= last.ctl.singular;
            saturated_reg <= saturated_next;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.point_x   = point_reg[0];
    assign res.point_y   = point_reg[1];
    assign res.point_z   = point_reg[2];
    assign res.singular  = singular_reg;
    assign res.saturated = saturated_reg;
endmodule

FILE: rtl/tpi_check.sv
`timescale 1ns / 1ps
module tpi_check (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] px,
    input logic [31:0] py,
    input logic [31:0] pz,
    input logic        singular,
    input logic        saturated
);
    // A singular result carries zero coordinates and no clipping.
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> px == 32'd0 && py == 32'd0 && pz == 32'd0 && !saturated)
        else $error("singular result with nonzero payload");

    // Clipping leaves at least one coordinate at a range limit.
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            px == 32'h7fffffff || px == 32'h80000000 ||
            py == 32'h7fffffff || py == 32'h80000000 ||
            pz == 32'h7fffffff || pz == 32'h80000000)
        else $error("saturated flag without a clipped coordinate");

    // Input is held off only while a result waits at the output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back-pressure");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(px) && $stable(py) && $stable(pz))
        else $error("result changed before its transfer");
endmodule

bind three_plane_intersection tpi_check u_tpi_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (query.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .px        (res.point_x),
    .py        (res.point_y),
    .pz        (res.point_z),
    .singular  (res.singular),
    .saturated (res.saturated)
);
